>>> design/pairwise_cutoff_contact_finder_macros.svh
// ----------------------------------------------------------------------------
// Contact finder assertion macros
// Shared concurrent assertion forms for the contact finder checker.
// ----------------------------------------------------------------------------
`ifndef PAIRWISE_CUTOFF_CONTACT_FINDER_MACROS_SVH
`define PAIRWISE_CUTOFF_CONTACT_FINDER_MACROS_SVH

// checked outside reset
`define PCF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define PCF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/pcf_pkg.sv
// ----------------------------------------------------------------------------
// Contact finder package
// Shared constants, codes and types of the pairwise contact finder.
// ----------------------------------------------------------------------------
package pcf_pkg;

  localparam int MAX_ATOMS_DEF = 64;
  localparam int COORD_W       = 24;
  localparam int INDEX_W       = 6;
  localparam int CUT_W         = 16;
  localparam int GAIN_W        = 32;
  localparam int CFG_IDX_W     = 1;

  localparam logic [CFG_IDX_W-1:0] REG_CUTOFF = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 1'b1;

  localparam logic [CUT_W-1:0]  CUTOFF_RST = 16'd2560;
  localparam logic [GAIN_W-1:0] GAIN_RST   = 32'd65536;

  typedef enum logic [3:0] {
    ST_IDLE, ST_NUM, ST_READ, ST_SQX, ST_SQY, ST_SQZ, ST_SUM,
    ST_TEST, ST_CALC, ST_PUSH, ST_NEXT, ST_FLUSH
  } pcf_state_t;

  typedef enum logic [2:0] {
    SP_IDLE, SP_MUL, SP_SQRT, SP_CHK, SP_DIV
  } spring_state_t;

  typedef struct packed {
    logic        start_num;
    logic        start_contact;
  } spring_cmd_t;

  typedef struct packed {
    logic        done;
    logic [15:0] r0;
    logic [31:0] kv;
    logic        sat;
  } spring_res_t;

  typedef struct packed {
    logic [INDEX_W-1:0] first;
    logic [INDEX_W-1:0] second;
    logic [15:0]        rest;
    logic [31:0]        value;
    logic               sat;
  } contact_t;

endpackage

>>> design/pcf_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pcf_ram #(
  parameter int WIDTH = 72,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/pcf_spring.sv
// ----------------------------------------------------------------------------
// Spring unit
// Shift-add multiplier, restoring square root and restoring divider that
// give rest length and gain * (cutoff / r0)^6, one step per cycle.
// ----------------------------------------------------------------------------
module pcf_spring (
  input  logic                clk,
  input  logic                rst,
  input  pcf_pkg::spring_cmd_t cmd,
  input  logic [15:0]         cutoff,
  input  logic [31:0]         gain,
  input  logic [31:0]         r2,
  output pcf_pkg::spring_res_t res
);

  pcf_pkg::spring_state_t state, state_next;

  logic [127:0] mcand, acc, acc_next, num_q;
  logic [15:0]  mval;
  logic [3:0]   bitc;
  logic [2:0]   rnd;
  logic         den_mode;
  logic [95:0]  den, rmd;
  logic [31:0]  rad, nlo, q, q_next;
  logic [17:0]  rem, rem_sh, trial;
  logic [15:0]  root, root_next;
  logic [3:0]   sqc;
  logic [4:0]   divc;
  logic [96:0]  div_sh;
  logic         div_ge, sq_ge;

  assign acc_next  = {acc[126:0], 1'b0} + (mval[bitc] ? mcand : 128'd0);
  assign rem_sh    = {rem[15:0], rad[31:30]};
  assign trial     = {root, 2'b01};
  assign sq_ge     = rem_sh >= trial;
  assign root_next = {root[14:0], sq_ge};
  assign div_sh    = {rmd, nlo[31]};
  assign div_ge    = div_sh >= {1'b0, den};
  assign q_next    = {q[30:0], div_ge};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pcf_pkg::SP_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      pcf_pkg::SP_IDLE: begin
        if (cmd.start_num) begin
          state_next = pcf_pkg::SP_MUL;
        end else if (cmd.start_contact) begin
          state_next = pcf_pkg::SP_SQRT;
        end
      end
      pcf_pkg::SP_MUL: begin
        if (bitc == 4'd0 && rnd == 3'd5) begin
          state_next = den_mode ? pcf_pkg::SP_CHK : pcf_pkg::SP_IDLE;
        end
      end
      pcf_pkg::SP_SQRT: begin
        if (sqc == 4'd0) begin
          state_next = (root_next == 16'd0) ? pcf_pkg::SP_IDLE : pcf_pkg::SP_MUL;
        end
      end
      pcf_pkg::SP_CHK: begin
        state_next = (num_q[127:32] >= den) ? pcf_pkg::SP_IDLE : pcf_pkg::SP_DIV;
      end
      pcf_pkg::SP_DIV: begin
        if (divc == 5'd0) begin
          state_next = pcf_pkg::SP_IDLE;
        end
      end
      default: state_next = pcf_pkg::SP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.done <= 1'b0;
    end else begin
      res.done <= 1'b0;
      unique case (state)
        pcf_pkg::SP_IDLE: begin
          if (cmd.start_num) begin
            mcand    <= {96'd0, gain};
            acc      <= '0;
            mval     <= cutoff;
            bitc     <= 4'd15;
            rnd      <= 3'd0;
            den_mode <= 1'b0;
          end else if (cmd.start_contact) begin
            rad  <= r2;
            rem  <= '0;
            root <= '0;
            sqc  <= 4'd15;
          end
        end
        pcf_pkg::SP_MUL: begin
          if (bitc == 4'd0) begin
            if (rnd == 3'd5) begin
              if (den_mode) begin
                den <= acc_next[95:0];
              end else begin
                num_q    <= acc_next;
                res.done <= 1'b1;
              end
            end else begin
              mcand <= acc_next;
              acc   <= '0;
              bitc  <= 4'd15;
              rnd   <= rnd + 3'd1;
            end
          end else begin
            acc  <= acc_next;
            bitc <= bitc - 4'd1;
          end
        end
        pcf_pkg::SP_SQRT: begin
          rem  <= sq_ge ? rem_sh - trial : rem_sh;
          root <= root_next;
          rad  <= {rad[29:0], 2'b00};
          sqc  <= sqc - 4'd1;
          if (sqc == 4'd0) begin
            res.r0 <= root_next;
            if (root_next == 16'd0) begin
              res.kv   <= '1;
              res.sat  <= 1'b1;
              res.done <= 1'b1;
            end else begin
              mcand    <= 128'd1;
              acc      <= '0;
              mval     <= root_next;
              bitc     <= 4'd15;
              rnd      <= 3'd0;
              den_mode <= 1'b1;
            end
          end
        end
        pcf_pkg::SP_CHK: begin
          if (num_q[127:32] >= den) begin
            res.kv   <= '1;
            res.sat  <= 1'b1;
            res.done <= 1'b1;
          end else begin
            rmd  <= num_q[127:32];
            nlo  <= num_q[31:0];
            q    <= '0;
            divc <= 5'd31;
          end
        end
        pcf_pkg::SP_DIV: begin
          rmd  <= div_ge ? 96'(div_sh - {1'b0, den}) : div_sh[95:0];
          nlo  <= {nlo[30:0], 1'b0};
          q    <= q_next;
          divc <= divc - 5'd1;
          if (divc == 5'd0) begin
            res.kv   <= q_next;
            res.sat  <= 1'b0;
            res.done <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

>>> design/pairwise_cutoff_contact_finder.sv
// ----------------------------------------------------------------------------
// Pairwise cutoff contact finder
// Stores atom positions and emits every earlier atom within the cutoff,
// except the one just before it, with rest length and spring constant.
// Sequence: an atom with index 0 or 1, or a full store, starts no search.
// Otherwise the unit forms gain*cutoff^6, then the squared distance to each
// earlier atom tested; per contact a sqrt, multiply, divide and hand-off (sqrt
// only at zero distance), then a flush, plus any output stall.
// Throughput: one atom at a time; the bit-serial spring unit sets the rate.
// Reset: synchronous; clears the atom count, registers to defaults, no output.
// ----------------------------------------------------------------------------
module pairwise_cutoff_contact_finder #(
  parameter int MAX_ATOMS = pcf_pkg::MAX_ATOMS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [pcf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data,
  input  logic                          atom_valid,
  output logic                          atom_stall,
  input  logic                          new_chain,
  input  logic signed [23:0]            pos_x,
  input  logic signed [23:0]            pos_y,
  input  logic signed [23:0]            pos_z,
  output logic                          contact_valid,
  input  logic                          contact_stall,
  output logic [5:0]                    first_atom,
  output logic [5:0]                    second_atom,
  output logic [15:0]                   rest_length,
  output logic [31:0]                   spring_value,
  output logic                          spring_saturated,
  output logic                          last_contact
);

  localparam int AW = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
  localparam int CW = $clog2(MAX_ATOMS + 1);
  localparam int DW = 3 * pcf_pkg::COORD_W;

  pcf_pkg::pcf_state_t  state, state_next;
  pcf_pkg::spring_cmd_t sp_cmd;
  pcf_pkg::spring_res_t sp_res;
  pcf_pkg::contact_t    hold;

  logic [15:0]        cutoff;
  logic [31:0]        gain;
  logic [CW-1:0]      atom_count, eff_cnt;
  logic [AW-1:0]      jidx, iidx;
  logic signed [23:0] px, py, pz;
  logic [31:0]        cut2;
  logic [DW-1:0]      rdata;
  logic signed [24:0] dsel;
  logic signed [49:0] sq_w;
  logic [49:0]        sq;
  logic [50:0]        acc;
  logic               hv, accept, full, out_free, hit, last_i, load_out;

  assign accept     = atom_valid && !atom_stall;
  assign atom_stall = state != pcf_pkg::ST_IDLE;
  assign eff_cnt    = new_chain ? '0 : atom_count;
  assign full       = eff_cnt >= CW'(MAX_ATOMS);
  assign out_free   = !contact_valid || !contact_stall;
  assign hit        = acc <= {19'd0, cut2};
  assign last_i     = iidx == AW'(jidx - AW'(2));
  assign load_out   = hv && out_free &&
                      (state == pcf_pkg::ST_PUSH || state == pcf_pkg::ST_FLUSH);

  pcf_ram #(.WIDTH(DW), .DEPTH(MAX_ATOMS)) u_ram (
    .clk   (clk),
    .we    (accept && !full),
    .waddr (eff_cnt[AW-1:0]),
    .wdata ({pos_x, pos_y, pos_z}),
    .raddr (iidx),
    .rdata (rdata)
  );

  pcf_spring u_spring (
    .clk    (clk),
    .rst    (rst),
    .cmd    (sp_cmd),
    .cutoff (cutoff),
    .gain   (gain),
    .r2     (acc[31:0]),
    .res    (sp_res)
  );

  always_comb begin
    unique case (state)
      pcf_pkg::ST_SQY: dsel = 25'(signed'(rdata[47:24])) - 25'(py);
      pcf_pkg::ST_SQZ: dsel = 25'(signed'(rdata[23:0])) - 25'(pz);
      default:         dsel = 25'(signed'(rdata[71:48])) - 25'(px);
    endcase
  end

  assign sq_w = dsel * dsel;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pcf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next           = state;
    sp_cmd.start_num     = 1'b0;
    sp_cmd.start_contact = 1'b0;
    unique case (state)
      pcf_pkg::ST_IDLE: begin
        if (accept && !full && eff_cnt >= CW'(2)) begin
          state_next       = pcf_pkg::ST_NUM;
          sp_cmd.start_num = 1'b1;
        end
      end
      pcf_pkg::ST_NUM:  if (sp_res.done) state_next = pcf_pkg::ST_READ;
      pcf_pkg::ST_READ: state_next = pcf_pkg::ST_SQX;
      pcf_pkg::ST_SQX:  state_next = pcf_pkg::ST_SQY;
      pcf_pkg::ST_SQY:  state_next = pcf_pkg::ST_SQZ;
      pcf_pkg::ST_SQZ:  state_next = pcf_pkg::ST_SUM;
      pcf_pkg::ST_SUM:  state_next = pcf_pkg::ST_TEST;
      pcf_pkg::ST_TEST: begin
        if (hit) begin
          state_next           = pcf_pkg::ST_CALC;
          sp_cmd.start_contact = 1'b1;
        end else begin
          state_next = pcf_pkg::ST_NEXT;
        end
      end
      pcf_pkg::ST_CALC: if (sp_res.done) state_next = pcf_pkg::ST_PUSH;
      pcf_pkg::ST_PUSH: if (!hv || out_free) state_next = pcf_pkg::ST_NEXT;
      pcf_pkg::ST_NEXT: state_next = last_i ? pcf_pkg::ST_FLUSH : pcf_pkg::ST_READ;
      pcf_pkg::ST_FLUSH: if (!hv || out_free) state_next = pcf_pkg::ST_IDLE;
      default: state_next = pcf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cutoff        <= pcf_pkg::CUTOFF_RST;
      gain          <= pcf_pkg::GAIN_RST;
      atom_count    <= '0;
      contact_valid <= 1'b0;
      hv            <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          pcf_pkg::REG_CUTOFF: cutoff <= cfg_data[15:0];
          pcf_pkg::REG_GAIN:   gain   <= cfg_data;
          default: ;
        endcase
      end
      // held word moves out; last one of an atom leaves from flush
      if (load_out) begin
        first_atom       <= hold.first;
        second_atom      <= hold.second;
        rest_length      <= hold.rest;
        spring_value     <= hold.value;
        spring_saturated <= hold.sat;
        last_contact     <= (state == pcf_pkg::ST_FLUSH);
        contact_valid    <= 1'b1;
      end else if (contact_valid && !contact_stall) begin
        contact_valid <= 1'b0;
      end
      unique case (state)
        pcf_pkg::ST_IDLE: begin
          if (accept) begin
            if (!full) begin
              atom_count <= eff_cnt + CW'(1);
            end else begin
              atom_count <= eff_cnt;
            end
            jidx <= eff_cnt[AW-1:0];
            iidx <= '0;
            px   <= pos_x;
            py   <= pos_y;
            pz   <= pos_z;
            cut2 <= cutoff * cutoff;
          end
        end
        pcf_pkg::ST_SQX: sq <= 50'(sq_w);
        pcf_pkg::ST_SQY: begin
          sq  <= 50'(sq_w);
          acc <= {1'b0, sq};
        end
        pcf_pkg::ST_SQZ: begin
          sq  <= 50'(sq_w);
          acc <= acc + {1'b0, sq};
        end
        pcf_pkg::ST_SUM: acc <= acc + {1'b0, sq};
        pcf_pkg::ST_PUSH: begin
          if (!hv || out_free) begin
            hv          <= 1'b1;
            hold.first  <= 6'(iidx);
            hold.second <= 6'(jidx);
            hold.rest   <= sp_res.r0;
            hold.value  <= sp_res.kv;
            hold.sat    <= sp_res.sat;
          end
        end
        pcf_pkg::ST_NEXT: if (!last_i) iidx <= iidx + AW'(1);
        pcf_pkg::ST_FLUSH: begin
          if (hv && out_free) begin
            hv <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

>>> design/pcf_checker.sv
// ----------------------------------------------------------------------------
// Contact finder checker
// Port-level assertions on the contact finder, bound to the top level.
// ----------------------------------------------------------------------------
`include "pairwise_cutoff_contact_finder_macros.svh"

module pcf_checker (
  input logic        clk,
  input logic        rst,
  input logic        contact_valid,
  input logic        contact_stall,
  input logic [5:0]  first_atom,
  input logic [5:0]  second_atom,
  input logic [15:0] rest_length,
  input logic [31:0] spring_value,
  input logic        spring_saturated
);

  `PCF_ASSERT(a_hold, contact_valid && contact_stall |=> contact_valid && $stable(spring_value) && $stable(first_atom), "stalled contact word changed")
  `PCF_ASSERT(a_gap, contact_valid |-> {1'b0, second_atom} >= {1'b0, first_atom} + 7'd2, "pair index gap below two")
  `PCF_ASSERT(a_zero, contact_valid && rest_length == 16'd0 |-> spring_saturated, "zero rest length not saturated")
  `PCF_ASSERT(a_sat, contact_valid && spring_saturated |-> spring_value == 32'hFFFFFFFF, "saturated spring not clipped")
  `PCF_ASSERT_ALWAYS(a_rst, rst |=> !contact_valid, "contact word after reset")

endmodule

bind pairwise_cutoff_contact_finder pcf_checker u_pcf_checker (.*);
